// File: sv/pics_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-sector package
// Shared constants and types for the point-in-circular-sector test block.
// ----------------------------------------------------------------------------
package pics_pkg;

   // Default coordinate width, in bits, of all signed fixed point coordinates.
   localparam int COORD_WIDTH_DEF = 24;

   // Number of bits in the configuration register index.
   localparam int CSR_INDEX_WIDTH = 3;

   // Configuration register map.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CENTER_X       = 3'd0,
      CSR_CENTER_Y       = 3'd1,
      CSR_EDGE0_X        = 3'd2,
      CSR_EDGE0_Y        = 3'd3,
      CSR_EDGE1_X        = 3'd4,
      CSR_EDGE1_Y        = 3'd5,
      CSR_RADIUS_SQUARED = 3'd6,
      CSR_REFLEX_MODE    = 3'd7
   } csr_index_type;

   // Load enables for the two register stages of a dot product unit.
   typedef struct packed {
      logic prod_en;
      logic sum_en;
   } dot_ctl_type;

endpackage

// File: sv/pics_req_if.sv
// ----------------------------------------------------------------------------
// Point request channel
// Valid/ready channel that carries one query point per item.
// ----------------------------------------------------------------------------
interface pics_req_if #(
   parameter int COORD_WIDTH = pics_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// File: sv/pics_rsp_if.sv
// ----------------------------------------------------------------------------
// Sector result channel
// Valid/ready channel that carries one inside flag per item.
// ----------------------------------------------------------------------------
interface pics_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, output inside_res, input ready);
   modport sink   (input valid, input inside_res, output ready);
endinterface

// File: sv/pics_dot2.sv
// ----------------------------------------------------------------------------
// Two-term dot product
// Computes a0*b0 + a1*b1 exactly over two register stages.
// ----------------------------------------------------------------------------
module pics_dot2 #(
   parameter int OP_WIDTH = pics_pkg::COORD_WIDTH_DEF + 1
) (
   input  logic                       clock,
   input  pics_pkg::dot_ctl_type      ctl,
   input  logic signed [OP_WIDTH-1:0] a0,
   input  logic signed [OP_WIDTH-1:0] b0,
   input  logic signed [OP_WIDTH-1:0] a1,
   input  logic signed [OP_WIDTH-1:0] b1,
   output logic signed [2*OP_WIDTH:0] sum
);

   localparam int PROD_WIDTH = 2 * OP_WIDTH;

   logic signed [PROD_WIDTH-1:0] p0_ff, p0_in;
   logic signed [PROD_WIDTH-1:0] p1_ff, p1_in;
   logic signed [PROD_WIDTH:0]   sum_ff, sum_in;

   assign p0_in  = a0 * b0;
   assign p1_in  = a1 * b1;
   assign sum_in = {p0_ff[PROD_WIDTH-1], p0_ff} + {p1_ff[PROD_WIDTH-1], p1_ff};

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
      end
      if (ctl.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// File: sv/point_in_circular_sector_test.sv
// ----------------------------------------------------------------------------
// Point-in-circular-sector test
// Checks one query point per item against a configured circular sector.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents                      Handshake
//  req_ch    in         point_x, point_y              valid / ready
//  rsp_ch    out        inside_res                    valid / ready
//  csr_*     in         register index, write data    write enable only
//
// The block takes one item per cycle while the result side does not stall.
// Four register stages hold an item in flight: one forms the offset from the
// center and loads at the accepting edge, one holds the products from the six
// multipliers, one holds the sums, and the last is the output register with
// the final compares.
// Reset clears the configuration registers and every stage valid bit.
// A stall on the result side backs up only as far as there are full stages;
// a stage with no item in it keeps accepting.
//
module point_in_circular_sector_test #(
   parameter int COORD_WIDTH = pics_pkg::COORD_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   pics_req_if.sink                               req_ch,
   pics_rsp_if.source                             rsp_ch,
   input  logic                                   csr_wr_en,
   input  logic [pics_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [2*COORD_WIDTH-2:0]               csr_wr_data
);

   // Offsets and negated edge components need one bit more than a coordinate.
   localparam int OP_WIDTH  = COORD_WIDTH + 1;
   localparam int SUM_WIDTH = 2 * OP_WIDTH + 1;
   localparam int RSQ_WIDTH = 2 * COORD_WIDTH - 1;

   // ------------------------------------------------------------------------
   // Configuration registers. Edge x components are kept negated so that
   // each cross product becomes a plain two-term dot product.
   // ------------------------------------------------------------------------
   logic signed [OP_WIDTH-1:0]  center_x_ff, center_y_ff;
   logic signed [OP_WIDTH-1:0]  edge0_y_ff, edge1_y_ff;
   logic signed [OP_WIDTH-1:0]  neg_edge0_x_ff, neg_edge1_x_ff;
   logic [RSQ_WIDTH-1:0]        radius_squared_ff;
   logic                        reflex_mode_ff;
   logic signed [OP_WIDTH-1:0]  csr_coord;
   logic signed [OP_WIDTH-1:0]  csr_coord_neg;

   // Sign-extend the low coordinate bits of the write data.
   assign csr_coord     = {csr_wr_data[COORD_WIDTH-1], csr_wr_data[COORD_WIDTH-1:0]};
   assign csr_coord_neg = OP_WIDTH'(0) - csr_coord;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff       <= '0;
         center_y_ff       <= '0;
         edge0_y_ff        <= '0;
         edge1_y_ff        <= '0;
         neg_edge0_x_ff    <= '0;
         neg_edge1_x_ff    <= '0;
         radius_squared_ff <= '0;
         reflex_mode_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (pics_pkg::csr_index_type'(csr_index))
            pics_pkg::CSR_CENTER_X:       center_x_ff       <= csr_coord;
            pics_pkg::CSR_CENTER_Y:       center_y_ff       <= csr_coord;
            pics_pkg::CSR_EDGE0_X:        neg_edge0_x_ff    <= csr_coord_neg;
            pics_pkg::CSR_EDGE0_Y:        edge0_y_ff        <= csr_coord;
            pics_pkg::CSR_EDGE1_X:        neg_edge1_x_ff    <= csr_coord_neg;
            pics_pkg::CSR_EDGE1_Y:        edge1_y_ff        <= csr_coord;
            pics_pkg::CSR_RADIUS_SQUARED: radius_squared_ff <= csr_wr_data;
            pics_pkg::CSR_REFLEX_MODE:    reflex_mode_ff    <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or when the
   // stage after it loads in the same cycle, so no item is dropped or
   // duplicated under any stall pattern.
   // ------------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, out_v_ff;
   logic rdy1, rdy2, rdy3, rdy_out;

   assign rdy_out      = !out_v_ff || rsp_ch.ready;
   assign rdy3         = !v3_ff || rdy_out;
   assign rdy2         = !v2_ff || rdy3;
   assign rdy1         = !v1_ff || rdy2;
   assign req_ch.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy1)    v1_ff    <= req_ch.valid;
         if (rdy2)    v2_ff    <= v1_ff;
         if (rdy3)    v3_ff    <= v2_ff;
         if (rdy_out) out_v_ff <= v3_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: offset from the center, exact in one extra bit.
   // ------------------------------------------------------------------------
   logic signed [OP_WIDTH-1:0] dx_ff, dx_in;
   logic signed [OP_WIDTH-1:0] dy_ff, dy_in;

   assign dx_in = {req_ch.point_x[COORD_WIDTH-1], req_ch.point_x} - center_x_ff;
   assign dy_in = {req_ch.point_y[COORD_WIDTH-1], req_ch.point_y} - center_y_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stages 2 and 3: squared distance and the two cross products.
   //   r2 = dx*dx + dy*dy
   //   c0 = dx*edge0_y + dy*(-edge0_x)
   //   c1 = dx*edge1_y + dy*(-edge1_x)
   // ------------------------------------------------------------------------
   pics_pkg::dot_ctl_type     dot_ctl;
   logic signed [SUM_WIDTH-1:0] r2_sum, c0_sum, c1_sum;

   assign dot_ctl.prod_en = rdy2;
   assign dot_ctl.sum_en  = rdy3;

   pics_dot2 #(.OP_WIDTH(OP_WIDTH)) u_dist (
      .clock (clock),
      .ctl   (dot_ctl),
      .a0    (dx_ff),
      .b0    (dx_ff),
      .a1    (dy_ff),
      .b1    (dy_ff),
      .sum   (r2_sum)
   );

   pics_dot2 #(.OP_WIDTH(OP_WIDTH)) u_cross0 (
      .clock (clock),
      .ctl   (dot_ctl),
      .a0    (dx_ff),
      .b0    (edge0_y_ff),
      .a1    (dy_ff),
      .b1    (neg_edge0_x_ff),
      .sum   (c0_sum)
   );

   pics_dot2 #(.OP_WIDTH(OP_WIDTH)) u_cross1 (
      .clock (clock),
      .ctl   (dot_ctl),
      .a0    (dx_ff),
      .b0    (edge1_y_ff),
      .a1    (dy_ff),
      .b1    (neg_edge1_x_ff),
      .sum   (c1_sum)
   );

   // ------------------------------------------------------------------------
   // Output stage. The point is on the start edge's counterclockwise side or on
   // it when c0 is not positive, and on the end edge's clockwise side or on it
   // when c1 is not negative. A reflex sector takes either test; an ordinary
   // one needs both. The squared distance is never negative, so it compares
   // against the radius as an unsigned value.
   // ------------------------------------------------------------------------
   logic start_ok, end_ok, angle_ok, radius_ok;
   logic inside_ff, inside_in;

   assign start_ok  = c0_sum[SUM_WIDTH-1] || (c0_sum == '0);
   assign end_ok    = !c1_sum[SUM_WIDTH-1];
   assign angle_ok  = reflex_mode_ff ? (start_ok || end_ok) : (start_ok && end_ok);
   assign radius_ok = $unsigned(r2_sum) <= SUM_WIDTH'(radius_squared_ff);
   assign inside_in = radius_ok && angle_ok;

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         inside_ff <= inside_in;
      end
   end

   assign rsp_ch.valid      = out_v_ff;
   assign rsp_ch.inside_res = inside_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // The input side only stalls when every stage holds an item.
   assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (v1_ff && v2_ff && v3_ff && out_v_ff))
      else $error("input stalled with an empty stage");

   // An accepted item always occupies the first stage in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> v1_ff)
      else $error("accepted item lost from first stage");

   // An item in the last sum stage that cannot move stays put.
   assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdy_out) |=> (v3_ff && $stable(c0_sum) && $stable(r2_sum)))
      else $error("stalled item in sum stage changed or vanished");

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Point-in-sector testbench
// Drives query points into the sector test block, predicts each inside flag
// from a shadow copy of the sector registers and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W = pics_pkg::COORD_WIDTH_DEF;
   localparam int RSQ_W = 2 * COORD_W - 1;

   // The block holds up to four items.
   localparam int PIPE_LATENCY = 4;

   // Longest quiet stretch is the long receiver hold-off plus a random gap.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   localparam int RANDOM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 65;
   localparam int PRESSURE_ITEMS = 40;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // Shadow copy of the sector registers, as the block should hold them.
   typedef struct {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] edge0_x;
      logic signed [COORD_W-1:0] edge0_y;
      logic signed [COORD_W-1:0] edge1_x;
      logic signed [COORD_W-1:0] edge1_y;
      logic [RSQ_W-1:0]          radius_squared;
      logic                      reflex_mode;
   } sector_cfg_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [pics_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [RSQ_W-1:0] csr_wr_data;

   pics_req_if #(.COORD_WIDTH(COORD_W)) req_if ();
   pics_rsp_if rsp_if ();

   point_in_circular_sector_test #(
      .COORD_WIDTH(COORD_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if.sink),
      .rsp_ch      (rsp_if.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   sector_cfg_type sector;           // register contents the block should hold
   logic expected_inside_q[$];       // inside flags of accepted items, oldest first
   int fail_count = 0;
   int sector_span = 0;              // rough radius of the current sector, in LSBs
   bit req_idle_on = 0;              // sender inserts random gaps
   bit rsp_idle_on = 0;              // receiver inserts random stalls
   int hold_len = 0;                 // request for one long receiver hold-off

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Exact sector test at 64 bits: the offset needs 25 bits, every product 50
   // and the sums 51, so nothing can overflow.
   function automatic logic predict_inside(input logic signed [COORD_W-1:0] px,
                                           input logic signed [COORD_W-1:0] py);
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic signed [63:0] dist_sq;
      logic signed [63:0] cross0;
      logic signed [63:0] cross1;
      logic signed [63:0] limit;
      logic start_ok;
      logic end_ok;
      logic span_ok;
      dx = 64'(px) - 64'(sector.center_x);
      dy = 64'(py) - 64'(sector.center_y);
      dist_sq = dx * dx + dy * dy;
      cross0 = dx * 64'(sector.edge0_y) - 64'(sector.edge0_x) * dy;
      cross1 = dx * 64'(sector.edge1_y) - 64'(sector.edge1_x) * dy;
      limit = 64'(sector.radius_squared);
      // A point on either edge ray counts as inside the span.
      start_ok = (cross0 <= 64'sd0);
      end_ok = (cross1 >= 64'sd0);
      span_ok = sector.reflex_mode ? (start_ok || end_ok) : (start_ok && end_ok);
      return (dist_sq <= limit) && span_ok;
   endfunction

   // -------------------------------------------------------------------------
   // Random helpers
   // -------------------------------------------------------------------------

   // Mostly back to back, sometimes a short gap, now and then a long gap.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Signed value of magnitude up to 2**k, wrapped to the coordinate width.
   function automatic logic signed [COORD_W-1:0] rand_coord(input int k);
      logic [63:0] mag;
      mag = 64'($urandom_range(0, 1 << k));
      return $urandom_range(0, 1) ? COORD_W'(mag) : COORD_W'(-mag);
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_edge();
      if ($urandom_range(0, 7) == 0) return '0;
      return rand_coord($urandom_range(0, COORD_W - 1));
   endfunction

   // Random sector whose radius is drawn over many scales; sets sector_span so
   // that points can be aimed at the circle.
   function automatic sector_cfg_type random_sector();
      sector_cfg_type c;
      logic [63:0] r;
      c.center_x = $urandom_range(0, 1) ? COORD_W'($urandom()) : rand_coord(12);
      c.center_y = $urandom_range(0, 1) ? COORD_W'($urandom()) : rand_coord(12);
      c.edge0_x = rand_edge();
      c.edge0_y = rand_edge();
      c.edge1_x = rand_edge();
      c.edge1_y = rand_edge();
      r = 64'($urandom_range(0, 1 << $urandom_range(0, COORD_W - 1)));
      sector_span = int'(r);
      case ($urandom_range(0, 15))
         0: begin
            c.radius_squared = '0;
            sector_span = 0;
         end
         1, 2: begin
            c.radius_squared = '1;
            sector_span = 1 << COORD_W;
         end
         default: c.radius_squared = RSQ_W'(r * r);
      endcase
      c.reflex_mode = 1'($urandom_range(0, 1));
      return c;
   endfunction

   // Points are aimed at the interesting places of the current sector: the
   // circle, both edge rays and the center, with some points fully random.
   function automatic void random_point(output logic signed [COORD_W-1:0] px,
                                        output logic signed [COORD_W-1:0] py);
      logic signed [63:0] ox;
      logic signed [63:0] oy;
      int mult;
      int nudge;
      int lim;
      ox = '0;
      oy = '0;
      case ($urandom_range(0, 9))
         0, 1: begin
            px = COORD_W'($urandom());
            py = COORD_W'($urandom());
            return;
         end
         2, 3: begin
            // On an edge ray or one LSB off it.
            mult = $urandom_range(0, 3);
            if ($urandom_range(0, 1)) begin
               ox = 64'(mult) * 64'(sector.edge0_x);
               oy = 64'(mult) * 64'(sector.edge0_y);
            end else begin
               ox = 64'(mult) * 64'(sector.edge1_x);
               oy = 64'(mult) * 64'(sector.edge1_y);
            end
            if ($urandom_range(0, 1)) begin
               nudge = $urandom_range(0, 2);
               nudge = nudge - 1;
               if ($urandom_range(0, 1)) ox = ox + 64'(nudge);
               else oy = oy + 64'(nudge);
            end
         end
         4: begin
            nudge = $urandom_range(0, 8);
            ox = 64'(nudge - 4);
            nudge = $urandom_range(0, 8);
            oy = 64'(nudge - 4);
         end
         default: begin
            lim = sector_span + sector_span / 8 + 2;
            ox = 64'($urandom_range(0, 2 * lim));
            ox = ox - 64'(lim);
            oy = 64'($urandom_range(0, 2 * lim));
            oy = oy - 64'(lim);
         end
      endcase
      px = COORD_W'(64'(sector.center_x) + ox);
      py = COORD_W'(64'(sector.center_y) + oy);
   endfunction

   // -------------------------------------------------------------------------
   // Shared tasks
   // -------------------------------------------------------------------------

   // Writes all eight registers back to back, then updates the shadow copy.
   // With junk set, the bits above each field's width carry random noise that
   // the block has to drop.
   task automatic load_sector(input sector_cfg_type c, input bit junk);
      pics_pkg::csr_index_type idx;
      logic [RSQ_W-1:0] word;
      logic [63:0] noise;
      idx = idx.first();
      do begin
         noise = {$urandom(), $urandom()};
         word = '0;
         case (idx)
            pics_pkg::CSR_CENTER_X:       word[COORD_W-1:0] = c.center_x;
            pics_pkg::CSR_CENTER_Y:       word[COORD_W-1:0] = c.center_y;
            pics_pkg::CSR_EDGE0_X:        word[COORD_W-1:0] = c.edge0_x;
            pics_pkg::CSR_EDGE0_Y:        word[COORD_W-1:0] = c.edge0_y;
            pics_pkg::CSR_EDGE1_X:        word[COORD_W-1:0] = c.edge1_x;
            pics_pkg::CSR_EDGE1_Y:        word[COORD_W-1:0] = c.edge1_y;
            pics_pkg::CSR_RADIUS_SQUARED: word = c.radius_squared;
            pics_pkg::CSR_REFLEX_MODE:    word[0] = c.reflex_mode;
            default:                      word = '0;
         endcase
         if (junk) begin
            if (idx == pics_pkg::CSR_REFLEX_MODE) begin
               word[RSQ_W-1:1] = noise[RSQ_W-2:0];
            end else if (idx != pics_pkg::CSR_RADIUS_SQUARED) begin
               word[RSQ_W-1:COORD_W] = noise[RSQ_W-COORD_W-1:0];
            end
         end
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wr_data <= word;
         @(posedge clock);
         idx = idx.next();
      end while (idx != idx.first());
      csr_wr_en <= 1'b0;
      sector = c;
   endtask

   // Offers one item, optionally after a random gap, and waits until it is
   // taken. Valid stays high on exit so that the next item can follow at once.
   task automatic send_point(input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py);
      int gap;
      logic want;
      gap = req_idle_on ? pick_gap() : 0;
      want = predict_inside(px, py);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.point_x <= px;
      req_if.point_y <= py;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_inside_q.push_back(want);
   endtask

   // Stops offering, waits for every outstanding result and lets the pipeline
   // settle, so that registers may be written safely afterwards.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_inside_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Registers at their reset values: zero edges pass any angle and a zero
   // radius leaves only the center itself inside.
   task automatic test_reset_state();
      sector = '{default: '0};
      send_point('0, '0);
      send_point(COORD_W'(1), '0);
      send_point(COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, '0);
      wait_idle();
   endtask

   // First quadrant sector of radius 10.0 around the origin. Points sit on the
   // edge rays, on the circle and just outside, first as an ordinary sector
   // and then with the reflex combination of the edge tests.
   task automatic test_sector_boundaries();
      sector_cfg_type c;
      c = '{default: '0};
      c.edge0_x = COORD_W'(256);
      c.edge1_y = COORD_W'(256);
      c.radius_squared = RSQ_W'(2560 * 2560);
      load_sector(c, 1'b0);
      send_point(COORD_W'(1280), '0);
      send_point('0, COORD_W'(1280));
      send_point(COORD_W'(2560), '0);
      send_point(COORD_W'(2561), '0);
      send_point('0, COORD_W'(-1));
      send_point(COORD_W'(1810), COORD_W'(1810));
      send_point(COORD_W'(1811), COORD_W'(1811));
      send_point(COORD_W'(-1), COORD_W'(5));
      wait_idle();

      c.reflex_mode = 1'b1;
      load_sector(c, 1'b0);
      send_point(COORD_W'(-1), COORD_W'(5));
      send_point(COORD_W'(-5), COORD_W'(-5));
      send_point(COORD_W'(-1811), COORD_W'(-1811));
      wait_idle();
   endtask

   // Center and points at opposite ends of the coordinate range give the
   // largest offsets and squared distances the block can see. Register
   // writes carry noise above the field widths.
   task automatic test_field_extremes();
      sector_cfg_type c;
      c = '{default: '0};
      c.center_x = COORD_MIN;
      c.center_y = COORD_MIN;
      c.radius_squared = '1;
      load_sector(c, 1'b1);
      send_point(COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, COORD_MIN);
      wait_idle();

      c.center_x = COORD_MAX;
      c.center_y = COORD_MAX;
      c.edge0_x = COORD_MIN;
      c.edge0_y = COORD_MAX;
      c.edge1_x = COORD_MAX;
      c.edge1_y = COORD_MIN;
      c.reflex_mode = 1'b1;
      load_sector(c, 1'b1);
      send_point(COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, COORD_MAX);
      send_point('0, '0);
      wait_idle();
   endtask

   // Phases of random sectors, each followed by points aimed at it. The first
   // two phases pin the registers to their extremes. Idling is switched off
   // on one side or both in some phases so that back to back stretches occur.
   task automatic test_random_sectors();
      sector_cfg_type c;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         c = random_sector();
         if (phase == 0) begin
            c.center_x = COORD_MAX;
            c.center_y = COORD_MIN;
            c.edge0_x = COORD_MAX;
            c.edge0_y = COORD_MAX;
            c.edge1_x = COORD_MIN;
            c.edge1_y = COORD_MIN;
            c.radius_squared = '1;
            c.reflex_mode = 1'b0;
            sector_span = 1 << COORD_W;
         end else if (phase == 1) begin
            c.center_x = COORD_MIN;
            c.center_y = COORD_MAX;
            c.edge0_x = COORD_MIN;
            c.edge0_y = COORD_MAX;
            c.edge1_x = COORD_MAX;
            c.edge1_y = COORD_MIN;
            c.radius_squared = '0;
            c.reflex_mode = 1'b1;
            sector_span = 0;
         end
         req_idle_on = (phase % 3 != 2);
         rsp_idle_on = (phase % 4 != 3);
         load_sector(c, phase[0]);
         repeat (ITEMS_PER_PHASE) begin
            random_point(px, py);
            send_point(px, py);
         end
         wait_idle();
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering items back to back, so the pipeline fills and stalls its input.
   task automatic test_output_backpressure();
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      load_sector(random_sector(), 1'b0);
      req_idle_on = 0;
      rsp_idle_on = 0;
      hold_len = HOLD_CYCLES;
      repeat (PRESSURE_ITEMS) begin
         random_point(px, py);
         send_point(px, py);
      end
      wait_idle();
      req_idle_on = 1;
      rsp_idle_on = 1;
   endtask

   // -------------------------------------------------------------------------
   // Result side
   // -------------------------------------------------------------------------

   // Receiver ready: random stalls when enabled, and one long hold-off on
   // request, counted down here one cycle at a time.
   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            stall_left = hold_len;
            hold_len = 0;
         end else if (stall_left == 0 && rsp_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Every accepted result is matched against the oldest expected flag.
   always @(posedge clock) begin : inside_checker
      logic want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_inside_q.size() == 0) begin
            $error("inside_res: no item outstanding, actual %0b", rsp_if.inside_res);
            fail_count++;
         end else begin
            want = expected_inside_q.pop_front();
            if (rsp_if.inside_res !== want) begin
               $error("inside_res mismatch: expected %0b, actual %0b",
                      want, rsp_if.inside_res);
               fail_count++;
            end
         end
      end
   end

   // Ends the run when nothing has been accepted on either channel for too
   // long, which catches a hung block as well as results that never come.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("simulation failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= pics_pkg::CSR_CENTER_X;
      csr_wr_data <= '0;
      req_if.valid <= 1'b0;
      req_if.point_x <= '0;
      req_if.point_y <= '0;
      sector = '{default: '0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_sector_boundaries();
      test_field_extremes();
      test_random_sectors();
      test_output_backpressure();
      wait_idle();

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: point_in_circular_sector_test.f
sv/pics_pkg.sv
sv/pics_req_if.sv
sv/pics_rsp_if.sv
sv/pics_dot2.sv
sv/point_in_circular_sector_test.sv
tb/sv/tb_top.sv
